FILE: sv/zbuffer_point_splat_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the z-buffer point splatter
// Property checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ZBUFFER_POINT_SPLAT_DEFINES_SVH
`define ZBUFFER_POINT_SPLAT_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ZBPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zbps assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ZBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zbps assertion failed");

`else

`define ZBPS_ASSERT_SAME(label, ante, cons)
`define ZBPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/zbps_pkg.sv
// ----------------------------------------------------------------------------
// zbps_pkg
// Shared types and constants of the z-buffer point splatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zbps_pkg;

  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 16;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 9;
  localparam int DIM_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_CHAN   = 3;

  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic        [COLOR_W-1:0]    color_t;
  typedef logic        [CHAN_W-1:0]     chan_t;
  typedef logic        [PIX_W-1:0]      pix_t;
  typedef logic        [DIM_W-1:0]      dim_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_ORIGIN_X     = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_Y     = 3'd1;
  localparam cfg_idx_t REG_SCALE_FACTOR = 3'd2;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd3;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd4;
  localparam cfg_idx_t REG_COLOR_MAX    = 3'd5;

  localparam coord_t    DEPTH_RESET        = 32'sh8000_0000;
  localparam chan_t     CHAN_FULL          = 8'd255;
  localparam cfg_data_t SCALE_FACTOR_RESET = 32'd65536;
  localparam dim_t      IMAGE_DIM_RESET    = 10'd512;
  localparam color_t    COLOR_MAX_RESET    = 16'hFFFF;

  // Scaled products carry 24 fraction bits (Q23.8 times Q16.16).
  localparam int PROD_FRAC = 24;

endpackage

`default_nettype wire

FILE: sv/zbps_cfg_if.sv
// ----------------------------------------------------------------------------
// zbps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface zbps_cfg_if;
  logic                valid;
  logic                ready;
  zbps_pkg::cfg_idx_t  index;
  zbps_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/zbps_point_if.sv
// ----------------------------------------------------------------------------
// zbps_point_if
// Input channel: one rotated point with its raw color per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface zbps_point_if;
  logic             valid;
  logic             ready;
  zbps_pkg::coord_t point_x;
  zbps_pkg::coord_t point_y;
  zbps_pkg::coord_t point_z;
  zbps_pkg::color_t red_in;
  zbps_pkg::color_t green_in;
  zbps_pkg::color_t blue_in;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

FILE: sv/zbps_pixel_if.sv
// ----------------------------------------------------------------------------
// zbps_pixel_if
// Output channel: one pixel write per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface zbps_pixel_if;
  logic            valid;
  logic            ready;
  zbps_pkg::pix_t  pixel_x;
  zbps_pkg::pix_t  pixel_y;
  zbps_pkg::chan_t red_out;
  zbps_pkg::chan_t green_out;
  zbps_pkg::chan_t blue_out;

  modport source (output valid, output pixel_x, output pixel_y, output red_out,
                  output green_out, output blue_out, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input red_out,
                  input green_out, input blue_out, output ready);
endinterface

`default_nettype wire

FILE: sv/zbuffer_point_splat.sv
// ----------------------------------------------------------------------------
// zbuffer_point_splat
// Z-buffer point splatting: projects rotated points onto the raster, keeps
// the nearest depth per pixel and emits a pixel write for each point that
// wins its depth test.
//
// Each point is offset by the configured origin, scaled by a Q16.16 factor
// (one shared 32x32 multiplier, x then y), clamped to the image and used to
// read its pixel's depth from a single-port-read on-chip depth store; a
// point with a greater depth overwrites the entry and has its color scaled
// to 0..255 by a three-lane divider that produces one quotient bit per
// cycle. A point that fails the depth test returns to ready straight after
// its depth read; a point that is written also waits for the divider's eight
// steps, plus any wait while the output register still holds an earlier
// pixel. Items are processed one at a time, so no two depth accesses
// overlap. After reset the depth store is cleared at one entry per cycle,
// during which no point is accepted; configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "zbuffer_point_splat_defines.svh"

module zbuffer_point_splat #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic          clk,
  input  wire logic          rst,
  zbps_cfg_if.sink           cfg,
  zbps_point_if.sink         point,
  zbps_pixel_if.source       pixel
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_COORD, S_TEST, S_DIV, S_EMIT} state_t;

  state_t                                        state;

  zbps_pkg::coord_t                              origin_x;
  zbps_pkg::coord_t                              origin_y;
  zbps_pkg::cfg_data_t                           scale_factor;
  zbps_pkg::dim_t                                image_width;
  zbps_pkg::dim_t                                image_height;
  zbps_pkg::color_t                              color_max;

  logic [31:0]                                   w_eff, h_eff;
  logic [XW-1:0]                                 col_max;
  logic [HW-1:0]                                 hgt;

  zbps_pkg::coord_t                              z_q;
  zbps_pkg::color_t [zbps_pkg::NUM_CHAN-1:0]     color_q;

  logic                                          accept;
  logic                                          coord_done;
  logic [XW-1:0]                                 col;
  logic [YW-1:0]                                 row;

  logic                                          mem_busy;
  logic                                          rd_en;
  logic [AW-1:0]                                 rd_addr;
  logic [AW-1:0]                                 addr_q;
  zbps_pkg::coord_t                              rd_data;
  logic                                          wr_en;

  logic                                          div_done;
  zbps_pkg::chan_t  [zbps_pkg::NUM_CHAN-1:0]     chan;

  logic                                          out_valid;
  logic                                          out_load;
  zbps_pkg::pix_t                                out_x, out_y;
  zbps_pkg::chan_t  [zbps_pkg::NUM_CHAN-1:0]     out_chan;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      scale_factor <= zbps_pkg::SCALE_FACTOR_RESET;
      image_width  <= zbps_pkg::IMAGE_DIM_RESET;
      image_height <= zbps_pkg::IMAGE_DIM_RESET;
      color_max    <= zbps_pkg::COLOR_MAX_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        zbps_pkg::REG_ORIGIN_X:     origin_x     <= zbps_pkg::coord_t'(cfg.data);
        zbps_pkg::REG_ORIGIN_Y:     origin_y     <= zbps_pkg::coord_t'(cfg.data);
        zbps_pkg::REG_SCALE_FACTOR: scale_factor <= cfg.data;
        zbps_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data[zbps_pkg::DIM_W-1:0];
        zbps_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[zbps_pkg::DIM_W-1:0];
        zbps_pkg::REG_COLOR_MAX:    color_max    <= cfg.data[zbps_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions in use: zero counts as one, and the raster size caps them.
  always_comb begin
    if (image_width == '0) begin
      w_eff = 32'd1;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(image_width);
    end
    if (image_height == '0) begin
      h_eff = 32'd1;
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = 32'(image_height);
    end
  end

  assign col_max = XW'(w_eff - 32'd1);
  assign hgt     = HW'(h_eff);

  assign point.ready = (state == S_IDLE) && !mem_busy;
  assign accept      = point.valid && point.ready;

  zbps_coord #(
    .XW (XW),
    .YW (YW),
    .HW (HW)
  ) u_coord (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .pos_x    (point.point_x),
    .pos_y    (point.point_y),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .scale    (scale_factor),
    .col_max  (col_max),
    .hgt      (hgt),
    .done     (coord_done),
    .col      (col),
    .row      (row)
  );

  assign rd_en   = (state == S_COORD) && coord_done;
  assign rd_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  assign wr_en   = (state == S_TEST) && (z_q > rd_data);

  zbps_depth_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_depth_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr_q),
    .wr_data (z_q),
    .busy    (mem_busy)
  );

  zbps_color_div u_color_div (
    .clk       (clk),
    .rst       (rst),
    .start     (wr_en),
    .color_in  (color_q),
    .color_max (color_max),
    .done      (div_done),
    .chan_out  (chan)
  );

  // The output register frees the divider as soon as it is loaded.
  assign out_load = ((state == S_DIV && div_done) || state == S_EMIT)
                    && (!out_valid || pixel.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_x    <= zbps_pkg::PIX_W'(col);
        out_y    <= zbps_pkg::PIX_W'(row);
        out_chan <= chan;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            z_q        <= point.point_z;
            color_q[0] <= point.red_in;
            color_q[1] <= point.green_in;
            color_q[2] <= point.blue_in;
            state      <= S_COORD;
          end
        end
        S_COORD: begin
          if (coord_done) begin
            addr_q <= rd_addr;
            state  <= S_TEST;
          end
        end
        S_TEST: begin
          state <= wr_en ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= out_load ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pixel.valid     = out_valid;
  assign pixel.pixel_x   = out_x;
  assign pixel.pixel_y   = out_y;
  assign pixel.red_out   = out_chan[0];
  assign pixel.green_out = out_chan[1];
  assign pixel.blue_out  = out_chan[2];

  `ZBPS_ASSERT_SAME(a_clear_blocks_items, mem_busy, state == S_IDLE && !point.ready)
  `ZBPS_ASSERT_SAME(a_coord_done_when_waiting, coord_done, state == S_COORD)
  `ZBPS_ASSERT_SAME(a_div_done_when_waiting, div_done, state == S_DIV)
  `ZBPS_ASSERT_NEXT(a_accept_starts_coord, accept, state == S_COORD)

endmodule

`default_nettype wire

FILE: sv/zbps_depth_mem.sv
// ----------------------------------------------------------------------------
// zbps_depth_mem
// Depth store: one write port, one registered read port, and a clearing
// pass after reset that fills every entry with the most negative depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbps_depth_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output zbps_pkg::coord_t      rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire zbps_pkg::coord_t wr_data,
  output logic                  busy
);

  zbps_pkg::coord_t mem [DEPTH];
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= zbps_pkg::DEPTH_RESET;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/zbps_coord.sv
// ----------------------------------------------------------------------------
// zbps_coord
// Maps a point to its pixel: origin offset, Q16.16 scaling on one shared
// multiplier (x, then y), truncation toward zero and clamping to the image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbps_coord #(
  parameter int XW = 9,
  parameter int YW = 9,
  parameter int HW = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire zbps_pkg::coord_t    pos_x,
  input  wire zbps_pkg::coord_t    pos_y,
  input  wire zbps_pkg::coord_t    origin_x,
  input  wire zbps_pkg::coord_t    origin_y,
  input  wire zbps_pkg::cfg_data_t scale,
  input  wire logic [XW-1:0]       col_max,
  input  wire logic [HW-1:0]       hgt,
  output logic                     done,
  output logic [XW-1:0]            col,
  output logic [YW-1:0]            row
);

  localparam int DW = zbps_pkg::COORD_W + 1;
  localparam int PW = 2 * zbps_pkg::COORD_W;
  localparam int QW = PW - zbps_pkg::PROD_FRAC;

  typedef enum logic [1:0] {C_IDLE, C_MULX, C_MULY, C_ROW} cstate_t;

  cstate_t                        state;
  logic signed [DW-1:0]           dx, dy;
  logic [zbps_pkg::COORD_W-1:0]   mag_x, mag_y;
  logic                           neg_x, neg_y;
  logic [PW-1:0]                  prod;
  logic [QW-1:0]                  q;
  logic [XW-1:0]                  col_next;
  logic [YW-1:0]                  row_next;
  logic [HW-1:0]                  hm1;

  assign dx  = DW'(pos_x) - DW'(origin_x);
  assign dy  = DW'(pos_y) - DW'(origin_y);
  assign q   = prod[PW-1:zbps_pkg::PROD_FRAC];
  assign hm1 = hgt - HW'(1);

  // A negative offset lands on column zero; a large one on the last column.
  always_comb begin
    if (neg_x) begin
      col_next = '0;
    end else if (q > QW'(col_max)) begin
      col_next = col_max;
    end else begin
      col_next = q[XW-1:0];
    end
  end

  // Rows count down from the image height, so a non-positive scaled y sits
  // on the bottom row and anything at or past the height on the top row.
  always_comb begin
    if (neg_y || (q == '0)) begin
      row_next = YW'(hm1);
    end else if (q >= QW'(hgt)) begin
      row_next = '0;
    end else begin
      row_next = YW'(hgt - q[HW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            neg_x <= dx[DW-1];
            neg_y <= dy[DW-1];
            mag_x <= dx[DW-1] ? zbps_pkg::COORD_W'(-dx) : zbps_pkg::COORD_W'(dx);
            mag_y <= dy[DW-1] ? zbps_pkg::COORD_W'(-dy) : zbps_pkg::COORD_W'(dy);
            state <= C_MULX;
          end
        end
        C_MULX: begin
          prod  <= mag_x * scale;
          state <= C_MULY;
        end
        C_MULY: begin
          prod  <= mag_y * scale;
          col   <= col_next;
          state <= C_ROW;
        end
        C_ROW: begin
          row   <= row_next;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/zbps_color_div.sv
// ----------------------------------------------------------------------------
// zbps_color_div
// Normalizes three color channels to 255*c/color_max in parallel lanes,
// one quotient bit per cycle per lane, saturating at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbps_color_div (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      start,
  input  wire zbps_pkg::color_t [zbps_pkg::NUM_CHAN-1:0] color_in,
  input  wire zbps_pkg::color_t                          color_max,
  output logic                                           done,
  output zbps_pkg::chan_t  [zbps_pkg::NUM_CHAN-1:0]      chan_out
);

  localparam int NW = zbps_pkg::COLOR_W + zbps_pkg::CHAN_W;
  localparam int CW = $clog2(zbps_pkg::CHAN_W);

  zbps_pkg::color_t                          m_eff;
  logic                                      busy;
  logic [CW-1:0]                             cnt;
  logic [NW-1:0]                             dsh;
  logic [NW-1:0]                             rem  [zbps_pkg::NUM_CHAN];
  zbps_pkg::chan_t                           quo  [zbps_pkg::NUM_CHAN];
  logic [zbps_pkg::NUM_CHAN-1:0]             sat;

  // A zero maximum behaves as one.
  assign m_eff = (color_max == '0) ? zbps_pkg::color_t'(1) : color_max;

  // A channel at or above the maximum always gives full scale, so the
  // divider only ever sees quotients below 255 and needs eight steps.
  always_comb begin
    for (int i = 0; i < zbps_pkg::NUM_CHAN; i++) begin
      chan_out[i] = sat[i] ? zbps_pkg::CHAN_FULL : quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(zbps_pkg::CHAN_W - 1);
        dsh  <= NW'(m_eff) << (zbps_pkg::CHAN_W - 1);
        for (int i = 0; i < zbps_pkg::NUM_CHAN; i++) begin
          rem[i] <= (NW'(color_in[i]) << zbps_pkg::CHAN_W) - NW'(color_in[i]);
          sat[i] <= (color_in[i] >= m_eff);
        end
      end else if (busy) begin
        for (int i = 0; i < zbps_pkg::NUM_CHAN; i++) begin
          if (rem[i] >= dsh) begin
            rem[i] <= rem[i] - dsh;
            quo[i] <= {quo[i][zbps_pkg::CHAN_W-2:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][zbps_pkg::CHAN_W-2:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/zbuffer_point_splat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbuffer_point_splat_tb
// Self-checking bench for the z-buffer point splatter. Points are streamed in
// bursts while the pixel side stalls on its own pattern. A scoreboard keeps a
// private depth raster and register copy, predicts the write of each point
// winning its depth test and compares each emitted pixel with the oldest one.
// ----------------------------------------------------------------------------

module zbuffer_point_splat_tb;
  import zbps_pkg::*;

  localparam int MAX_W         = 512;
  localparam int MAX_H         = 512;
  localparam int RANDOM_POINTS = 1120;
  localparam int RANDOM_PHASES = 6;
  localparam int DRAIN_CYCLES  = 48;
  localparam int STALL_LIMIT   = 4 * MAX_W * MAX_H;
  localparam int REPORT_MAX    = 10;
  localparam longint SPAN_MAX  = 64'h7FFF_FFFF;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    color_t red;
    color_t green;
    color_t blue;
  } point_t;

  typedef struct packed {
    pix_t  x;
    pix_t  y;
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  class splat_scoreboard;
    coord_t      org_x;
    coord_t      org_y;
    logic [31:0] scale;
    dim_t        width;
    dim_t        height;
    color_t      cmax;
    int          depth_mem [];
    pixel_t      pixel_q [$];
    int          mismatches;

    function new();
      org_x      = '0;
      org_y      = '0;
      scale      = SCALE_FACTOR_RESET;
      width      = IMAGE_DIM_RESET;
      height     = IMAGE_DIM_RESET;
      cmax       = COLOR_MAX_RESET;
      mismatches = 0;
      depth_mem  = new[MAX_W * MAX_H];
      foreach (depth_mem[i]) depth_mem[i] = DEPTH_RESET;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_ORIGIN_X:     org_x  = data;
        REG_ORIGIN_Y:     org_y  = data;
        REG_SCALE_FACTOR: scale  = data;
        REG_IMAGE_WIDTH:  width  = data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height = data[DIM_W-1:0];
        REG_COLOR_MAX:    cmax   = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function int dim_used(dim_t v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
    endfunction

    // The offset is exact at 33 bits; the product is truncated toward zero.
    function longint scaled_offset(coord_t pos, coord_t org);
      longint      diff;
      logic [63:0] mag;
      logic [63:0] prod;
      diff = longint'(pos) - longint'(org);
      mag  = (diff < 0) ? -diff : diff;
      prod = (mag * {32'd0, scale}) >> PROD_FRAC;
      return (diff < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function longint clamp_to(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function chan_t norm_chan(color_t c);
      longint q;
      q = (longint'(c) * 255) / ((cmax == 0) ? 64'sd1 : longint'(cmax));
      return (q > 255) ? CHAN_FULL : chan_t'(q);
    endfunction

    function void note_point(point_t p);
      int     w;
      int     h;
      longint col;
      longint row;
      int     idx;
      w   = dim_used(width, MAX_W);
      h   = dim_used(height, MAX_H);
      col = clamp_to(scaled_offset(p.x, org_x), w - 1);
      row = clamp_to(h - scaled_offset(p.y, org_y), h - 1);
      idx = int'(row) * MAX_W + int'(col);
      if (int'(p.z) > depth_mem[idx]) begin
        depth_mem[idx] = int'(p.z);
        pixel_q.push_back('{pix_t'(col), pix_t'(row), norm_chan(p.red),
                            norm_chan(p.green), norm_chan(p.blue)});
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel write: x=%0d y=%0d rgb=%0d,%0d,%0d",
                   got.x, got.y, got.red, got.green, got.blue);
        return;
      end
      want = pixel_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("pixel write wrong: expected x=%0d y=%0d rgb=%0d,%0d,%0d, got x=%0d y=%0d rgb=%0d,%0d,%0d",
                   want.x, want.y, want.red, want.green, want.blue,
                   got.x, got.y, got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  zbps_cfg_if   cfg_bus ();
  zbps_point_if point_bus ();
  zbps_pixel_if pixel_bus ();

  zbuffer_point_splat #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .point (point_bus),
    .pixel (pixel_bus)
  );

  splat_scoreboard sb = new();
  int              idle_cycles = 0;
  coord_t          recent_x [8] = '{default: '0};
  coord_t          recent_y [8] = '{default: '0};
  int              recent_head = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Handshakes are sampled mid-cycle, where every signal is settled until the
  // next rising edge, so the item counts as accepted at that edge.
  always @(negedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_reg(cfg_bus.index, cfg_bus.data);
        moved = 1'b1;
      end
      if (point_bus.valid && point_bus.ready) begin
        sb.note_point('{point_bus.point_x, point_bus.point_y, point_bus.point_z,
                        point_bus.red_in, point_bus.green_in, point_bus.blue_in});
        moved = 1'b1;
      end
      if (pixel_bus.valid && pixel_bus.ready) begin
        sb.check_pixel('{pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.red_out,
                         pixel_bus.green_out, pixel_bus.blue_out});
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // The limit covers the depth clear after reset, which accepts no point.
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("zbuffer_point_splat: mismatch");
    $finish;
  end

  // Pixel side: phases of always ready, random ready and long stalls.
  initial begin : pixel_stall
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    pixel_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: pixel_bus.ready <= 1'b1;
        1: pixel_bus.ready <= 1'($urandom_range(0, 1));
        2: pixel_bus.ready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (hold > 0) begin
            hold--;
            pixel_bus.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(4, 24);
            pixel_bus.ready <= 1'b0;
          end else begin
            pixel_bus.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Leaves valid high so a following item goes out back to back.
  task automatic send_point(point_t p);
    point_bus.valid    <= 1'b1;
    point_bus.point_x  <= p.x;
    point_bus.point_y  <= p.y;
    point_bus.point_z  <= p.z;
    point_bus.red_in   <= p.red;
    point_bus.green_in <= p.green;
    point_bus.blue_in  <= p.blue;
    @(negedge clk);
    while (!point_bus.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pause_points(int cycles);
    point_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // A point that loses its depth test leaves no trace, so after the last
  // expected pixel the block is given time to finish any such point.
  task automatic drain_block();
    point_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(negedge clk);
    while (!cfg_bus.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic configure(cfg_data_t ox, cfg_data_t oy, cfg_data_t sc,
                           cfg_data_t w, cfg_data_t h, cfg_data_t cm);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_SCALE_FACTOR, sc);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_COLOR_MAX, cm);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offset from the origin that lands mostly inside the image, a bit beyond.
  function automatic longint pick_offset(dim_t dim, int maxv);
    longint span;
    if (sb.scale == 0)
      span = SPAN_MAX;
    else
      span = ((longint'(sb.dim_used(dim, maxv)) << PROD_FRAC) / longint'(sb.scale)) + 1;
    if (span > SPAN_MAX) span = SPAN_MAX;
    return longint'($urandom_range(0, span + span / 8)) - span / 16;
  endfunction

  function automatic color_t pick_color();
    if ($urandom_range(0, 2) == 0) return color_t'($urandom_range(0, sb.cmax));
    return color_t'($urandom());
  endfunction

  function automatic point_t random_point();
    point_t p;
    int     kind;
    int     slot;
    kind    = $urandom_range(0, 99);
    p.z     = $urandom();
    p.red   = pick_color();
    p.green = pick_color();
    p.blue  = pick_color();
    if (kind < 15) begin
      p.x = $urandom();
      p.y = $urandom();
    end else if (kind < 45) begin
      // Revisit a recent location so the depth test sees both outcomes.
      slot = $urandom_range(0, 7);
      p.x  = recent_x[slot];
      p.y  = recent_y[slot];
    end else begin
      p.x = sb.org_x + coord_t'(pick_offset(sb.width, MAX_W));
      p.y = sb.org_y + coord_t'(pick_offset(sb.height, MAX_H));
      recent_x[recent_head] = p.x;
      recent_y[recent_head] = p.y;
      recent_head = (recent_head + 1) % 8;
    end
    return p;
  endfunction

  function automatic cfg_data_t pick_origin();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return cfg_data_t'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  function automatic cfg_data_t pick_dim();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 16);
      1: return $urandom_range(0, 1023);
      2: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return 1;
          2: return 511;
          3: return 512;
          4: return 513;
          default: return 1023;
        endcase
      end
      default: return $urandom_range(17, 512);
    endcase
  endfunction

  initial begin : stimulus
    int        sent;
    int        quota;
    int        burst;
    bit        paused;
    cfg_data_t scale_pick;
    cfg_data_t cmax_pick;
    rst <= 1'b1;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_ORIGIN_X;
    cfg_bus.data       <= '0;
    point_bus.valid    <= 1'b0;
    point_bus.point_x  <= '0;
    point_bus.point_y  <= '0;
    point_bus.point_z  <= '0;
    point_bus.red_in   <= '0;
    point_bus.green_in <= '0;
    point_bus.blue_in  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, unit scale: pixel units are the integer part of x and y.
    configure(32'd0, 32'd0, SCALE_FACTOR_RESET, IMAGE_DIM_RESET, IMAGE_DIM_RESET,
              COLOR_MAX_RESET);
    send_point('{32'sd0, 32'sd0, 32'sd100, 16'd0, 16'hFFFF, 16'h8000});
    send_point('{32'sd0, 32'sd0, 32'sd100, 16'd1, 16'd2, 16'd3});      // equal depth
    send_point('{32'sd255, 32'sd255, 32'sd101, 16'd9, 16'd99, 16'd999});
    send_point('{32'sd2560, 32'sd2560, DEPTH_RESET, 16'hFFFF, 16'd0, 16'd1});
    send_point('{32'sd2560, 32'sd2560, 32'sh7FFF_FFFF, 16'd1, 16'd257, 16'hFFFE});
    send_point('{32'sd2560, 32'sd2560, 32'sh7FFF_FFFF, 16'd5, 16'd5, 16'd5});
    send_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_point('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd5, 16'h5555, 16'hAAAA, 16'h0F0F});
    send_point('{-32'sd1, 32'sd131072, 32'sd7, 16'h00FF, 16'hFF00, 16'h1234});
    send_point('{32'sd1000, 32'sd131071, 32'sd9, 16'd100, 16'd200, 16'd300});
    send_point('{-32'sd256, -32'sd256, 32'sd200, 16'd65534, 16'd1, 16'd0});
    drain_block();

    // Zero scale and dimensions: every point lands on the single pixel.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    send_point('{32'sd0, 32'sd0, 32'sd1000, 16'd0, 16'd1, 16'hFFFF});
    send_point('{32'sh1234_5678, -32'sd99, 32'sd999, 16'd7, 16'd7, 16'd7});
    send_point('{-32'sd5, 32'sd5, 32'sh7FFF_FFFF, 16'd0, 16'd0, 16'd0});
    drain_block();

    // Largest scale with dimensions above the raster and a tiny color range.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1023, 32'd600, 32'd1);
    send_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd11, 16'd0, 16'd1, 16'd2});
    send_point('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd300, 16'hFFFF, 16'd0, 16'd1});
    send_point('{32'sd0, 32'sh7FFF_FF00, 32'sd60, 16'd3, 16'd1, 16'd0});
    drain_block();

    // Small image, four pixels per unit.
    configure(32'd0, 32'd0, 32'd262144, 32'd8, 32'd8, 32'd255);
    send_point('{32'sd256, 32'sd256, 32'sd1, 16'd255, 16'd256, 16'd128});
    send_point('{32'sd320, 32'sd300, 32'sd0, 16'd254, 16'd1, 16'd0});
    send_point('{32'sd448, 32'sd512, 32'sd2, 16'hFFFF, 16'd127, 16'd64});
    send_point('{-32'sd64, 32'sd64, -32'sd8, 16'd10, 16'd20, 16'd30});
    drain_block();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0: scale_pick = SCALE_FACTOR_RESET;
        1: scale_pick = SCALE_FACTOR_RESET << $urandom_range(1, 6);
        2: scale_pick = SCALE_FACTOR_RESET >> $urandom_range(1, 8);
        3: scale_pick = $urandom();
        4: scale_pick = 32'hFFFF_FFFF;
        default: scale_pick = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 5))
        0: cmax_pick = 32'd0;
        1: cmax_pick = 32'd1;
        2: cmax_pick = 32'd255;
        3: cmax_pick = COLOR_MAX_RESET;
        default: cmax_pick = $urandom_range(0, 65535);
      endcase
      configure(pick_origin(), pick_origin(), scale_pick, pick_dim(), pick_dim(),
                cmax_pick);

      quota  = RANDOM_POINTS / RANDOM_PHASES;
      sent   = 0;
      paused = 1'b0;
      while (sent < quota) begin
        burst = $urandom_range(1, 16);
        for (int i = 0; i < burst && sent < quota; i++) begin
          send_point(random_point());
          sent++;
        end
        // Halfway through, hold off until the block has emptied.
        if (!paused && sent >= quota / 2) begin
          paused = 1'b1;
          drain_block();
        end else if ($urandom_range(0, 2) != 0) begin
          pause_points($urandom_range(1, 8));
        end
      end
      drain_block();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("zbuffer_point_splat: match");
    else
      $display("zbuffer_point_splat: mismatch");
    $finish;
  end

endmodule
